// ===== rtl/hmmp_pkg.sv =====
// Package: shared constants of the hemisphere partition unit.
`default_nettype none
package hmmp_pkg;
  localparam int unsigned VecW = 23;
  localparam int unsigned EW = 22;
  localparam logic [1:0] OpJet = 2'd0;
  localparam logic [1:0] OpLep = 2'd1;
  localparam logic [1:0] OpEnd = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/hemisphere_min_mass_partition_unit.sv =====
// Top level: collects jets and leptons, searches the minimum-mass hemisphere split.
// Jet and lepton words are accepted one per cycle while the unit is loading.
// An end word stalls input while the search visits every split of the n jets: each split reads
// and sums every jet, then evaluates the masses once without leptons or twice with two.
// One result word per end word; the output register lets the next event load meanwhile.
// Reset clears counts, flags and control; jet memory is undefined until written.
`default_nettype none
module hemisphere_min_mass_partition_unit #(
  parameter int unsigned MAX_JETS = 12,
  parameter int unsigned COMPONENT_BITS = 18
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid_i,
  output logic      s_axis_tready_o,
  // px, py, pz, energy
  input  wire logic [(((4*COMPONENT_BITS - 1) + 7) / 8)*8-1:0] s_axis_tdata_i,
  // op
  input  wire logic [1:0] s_axis_tuser_i,
  output logic      m_axis_tvalid_o,
  input  wire logic m_axis_tready_i,
  // lead_px, lead_py, lead_pz, lead_e, sub_px, sub_py, sub_pz, sub_e
  output logic [183:0] m_axis_tdata_o,
  // found, jet_overflow
  output logic [1:0] m_axis_tuser_o
);
  localparam int unsigned CB = COMPONENT_BITS;
  localparam int unsigned JW = $clog2(MAX_JETS + 1);
  localparam int unsigned AW = (MAX_JETS > 1) ? $clog2(MAX_JETS) : 1;
  localparam int unsigned VW = hmmp_pkg::VecW;
  localparam int unsigned EW = hmmp_pkg::EW;
  localparam int unsigned SW = CB + 6;
  localparam int unsigned MW = 2*SW + 4;

  typedef struct packed {
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] z;
    logic signed [SW-1:0] e;
  } vec_t;

  typedef enum logic [2:0] {
    ST_LOAD, ST_READ, ST_ACC, ST_LEP, ST_MSQ, ST_CMP, ST_PT, ST_OUT
  } state_e;

  logic [1:0] op;
  vec_t in_v;
  assign op = s_axis_tuser_i;
  assign in_v.x = SW'($signed(s_axis_tdata_i[0 +: CB]));
  assign in_v.y = SW'($signed(s_axis_tdata_i[CB +: CB]));
  assign in_v.z = SW'($signed(s_axis_tdata_i[2*CB +: CB]));
  assign in_v.e = SW'({1'b0, s_axis_tdata_i[3*CB +: CB-1]});

  vec_t jet_mem [MAX_JETS];
  vec_t rd_q;
  vec_t lep_q [2];
  logic [JW-1:0] jcnt_q;
  logic [1:0] lcnt_q;
  logic ovf_q;
  state_e st_q;
  logic [MAX_JETS-1:0] mask_q;
  logic [JW-1:0] k_q;
  logic swap_q;
  vec_t s1_q, s2_q, h1_q, h2_q, b1_q, b2_q;
  logic signed [MW-1:0] ma_q, mb_q, best_q, pa_q;
  logic valid_q, outv_q;
  logic [183:0] out_q;

  logic acc_ok;
  assign acc_ok = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (st_q == ST_LOAD) && !(op == hmmp_pkg::OpEnd && outv_q);
  assign m_axis_tvalid_o = outv_q;
  assign m_axis_tdata_o = {2'b00, out_q[181:0]};
  assign m_axis_tuser_o = out_q[183:182];

  logic [AW-1:0] rd_a;
  assign rd_a = k_q[AW-1:0];
  always_ff @(posedge clk_i) begin
    if (acc_ok && op == hmmp_pkg::OpJet && jcnt_q < JW'(MAX_JETS)) begin
      jet_mem[jcnt_q[AW-1:0]] <= in_v;
    end
    rd_q <= jet_mem[rd_a];
    if (acc_ok && op == hmmp_pkg::OpLep && lcnt_q < 2'd2) begin
      lep_q[lcnt_q[0]] <= in_v;
    end
  end

  function automatic logic signed [MW-1:0] msq(vec_t v);
    logic signed [2*SW-1:0] ee, xx, yy, zz;
    ee = v.e * v.e;
    xx = v.x * v.x;
    yy = v.y * v.y;
    zz = v.z * v.z;
    return MW'(ee) - MW'(xx) - MW'(yy) - MW'(zz);
  endfunction
  function automatic logic signed [MW-1:0] ptsq(vec_t v);
    logic signed [2*SW-1:0] xx, yy;
    xx = v.x * v.x;
    yy = v.y * v.y;
    return MW'(xx) + MW'(yy);
  endfunction
  function automatic vec_t vsum(vec_t a, vec_t b);
    vec_t r;
    r.x = a.x + b.x; r.y = a.y + b.y; r.z = a.z + b.z; r.e = a.e + b.e;
    return r;
  endfunction

  logic [MAX_JETS-1:0] last;
  logic bit_k;
  logic signed [MW-1:0] msum;
  assign last = MAX_JETS'((({{(MAX_JETS+1){1'b0}}} | 1'b1) << jcnt_q) - 2);
  assign bit_k = mask_q[AW'(jcnt_q - 1'b1 - k_q)];
  assign msum = ma_q + mb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_LOAD;
      jcnt_q <= '0;
      lcnt_q <= '0;
      ovf_q <= 1'b0;
      outv_q <= 1'b0;
      valid_q <= 1'b0;
      k_q <= '0;
      swap_q <= 1'b0;
      mask_q <= '0;
    end else begin
      if (outv_q && m_axis_tready_i) outv_q <= 1'b0;
      else if (st_q == ST_OUT) outv_q <= 1'b1;
      case (st_q)
        ST_LOAD: begin
          if (acc_ok) begin
            case (op)
              hmmp_pkg::OpJet: begin
                if (jcnt_q < JW'(MAX_JETS)) jcnt_q <= jcnt_q + 1'b1;
                else ovf_q <= 1'b1;
              end
              hmmp_pkg::OpLep: if (lcnt_q != 2'd3) lcnt_q <= lcnt_q + 1'b1;
              hmmp_pkg::OpEnd: begin
                valid_q <= 1'b0;
                b1_q <= '0;
                b2_q <= '0;
                if (jcnt_q >= JW'(2) && (lcnt_q == 2'd0 || lcnt_q == 2'd2)) begin
                  mask_q <= MAX_JETS'(1);
                  k_q <= '0;
                  s1_q <= '0;
                  s2_q <= '0;
                  st_q <= ST_READ;
                end else st_q <= ST_PT;
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          st_q <= ST_ACC;
        end
        ST_ACC: begin
          if (bit_k) s1_q <= vsum(s1_q, rd_q);
          else s2_q <= vsum(s2_q, rd_q);
          if (k_q == jcnt_q - 1'b1) begin
            swap_q <= 1'b0;
            st_q <= ST_LEP;
          end else begin
            k_q <= k_q + 1'b1;
            st_q <= ST_READ;
          end
        end
        ST_LEP: begin
          if (lcnt_q == 2'd0) begin
            h1_q <= s1_q;
            h2_q <= s2_q;
          end else begin
            h1_q <= vsum(s1_q, lep_q[swap_q]);
            h2_q <= vsum(s2_q, lep_q[!swap_q]);
          end
          st_q <= ST_MSQ;
        end
        ST_MSQ: begin
          ma_q <= msq(h1_q);
          mb_q <= msq(h2_q);
          st_q <= ST_CMP;
        end
        ST_CMP: begin
          if (!valid_q || best_q < 0 || msum < best_q) begin
            valid_q <= 1'b1;
            best_q <= msum;
            b1_q <= h1_q;
            b2_q <= h2_q;
          end
          if (lcnt_q == 2'd2 && !swap_q) begin
            swap_q <= 1'b1;
            st_q <= ST_LEP;
          end else if (mask_q == last) begin
            st_q <= ST_PT;
          end else begin
            mask_q <= mask_q + 1'b1;
            k_q <= '0;
            s1_q <= '0;
            s2_q <= '0;
            st_q <= ST_READ;
          end
        end
        ST_PT: begin
          pa_q <= ptsq(b1_q);
          ma_q <= ptsq(b2_q);
          st_q <= ST_OUT;
        end
        ST_OUT: begin
          if (pa_q > ma_q)
            out_q <= {ovf_q, valid_q, EW'(b2_q.e), VW'(b2_q.z), VW'(b2_q.y), VW'(b2_q.x),
                      EW'(b1_q.e), VW'(b1_q.z), VW'(b1_q.y), VW'(b1_q.x)};
          else
            out_q <= {ovf_q, valid_q, EW'(b1_q.e), VW'(b1_q.z), VW'(b1_q.y), VW'(b1_q.x),
                      EW'(b2_q.e), VW'(b2_q.z), VW'(b2_q.y), VW'(b2_q.x)};
          jcnt_q <= '0;
          lcnt_q <= '0;
          ovf_q <= 1'b0;
          st_q <= ST_LOAD;
        end
        default: st_q <= ST_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire
